FILE: src/octahedral_normal_encoder_assert.svh
// Assertion macros for the octahedral normal encoder checker.
`ifndef OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH
`define OCTAHEDRAL_NORMAL_ENCODER_ASSERT_SVH

// Implication checked on every clock edge outside reset.
`define ONE_CHECK(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Implication checked on every clock edge, reset included.
`define ONE_CHECK_ALWAYS(label, clk, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);

`endif

FILE: src/one_pkg.sv
// ----------------------------------------------------------------------------
// one_pkg: shared constants for the octahedral normal encoder
// The fixed field widths of the packed code.
// ----------------------------------------------------------------------------
package one_pkg;

  localparam int unsigned CODE_SLOT = 16;
  localparam int unsigned PACKED_BITS = 2 * CODE_SLOT;

endpackage

FILE: src/one_front.sv
// ----------------------------------------------------------------------------
// one_front: magnitude, octant fold and numerator setup
// Registers m, the two folded numerators t (n + m for z > 0) and the zero flag.
// ----------------------------------------------------------------------------
module one_front
  import one_pkg::*;
#(
  parameter int unsigned CB = 16
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  input  logic signed [CB-1:0] x,
  input  logic signed [CB-1:0] y,
  input  logic signed [CB-1:0] z,
  output logic                q_valid,
  output logic [CB+1:0]       q_m,
  output logic [CB+2:0]       q_tu,
  output logic [CB+2:0]       q_tv,
  output logic                q_zero
);
  localparam int unsigned MW = CB + 2;

  logic [MW-1:0] ax, ay, az, m;
  logic [MW:0]   tu, tv;
  logic          valid_r;
  logic [MW-1:0] m_r;
  logic [MW:0]   tu_r, tv_r;
  logic          zero_r;

  // magnitudes, full range of the most negative value
  always_comb begin
    ax = x[CB-1] ? MW'(-$signed({{2{x[CB-1]}}, x})) : MW'(x);
    ay = y[CB-1] ? MW'(-$signed({{2{y[CB-1]}}, y})) : MW'(y);
    az = z[CB-1] ? MW'(-$signed({{2{z[CB-1]}}, z})) : MW'(z);
    m  = ax + ay + az;
    if (!z[CB-1] && (z != '0)) begin
      tu = x[CB-1] ? ({1'b0, m} - {1'b0, ax}) : ({1'b0, m} + {1'b0, ax});
      tv = y[CB-1] ? ({1'b0, m} - {1'b0, ay}) : ({1'b0, m} + {1'b0, ay});
    end else begin
      tu = x[CB-1] ? {1'b0, ay} : ({m, 1'b0} - {1'b0, ay});
      tv = y[CB-1] ? {1'b0, ax} : ({m, 1'b0} - {1'b0, ax});
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) valid_r <= 1'b0;
    else valid_r <= in_valid;
    m_r    <= m;
    tu_r   <= tu;
    tv_r   <= tv;
    zero_r <= (m == '0);
  end

  assign q_valid = valid_r;
  assign q_m     = m_r;
  assign q_tu    = tu_r;
  assign q_tv    = tv_r;
  assign q_zero  = zero_r;
endmodule

FILE: src/one_div.sv
// ----------------------------------------------------------------------------
// one_div: pipelined restoring divider, one quotient bit per stage
// Computes floor(num / den) for the code; pass-through tag travels along.
// ----------------------------------------------------------------------------
module one_div #(
  parameter int unsigned NW = 36,
  parameter int unsigned DW = 19,
  parameter int unsigned QW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  input  logic          in_tag,
  output logic          out_valid,
  output logic [QW-1:0] quo,
  output logic          out_tag
);
  // quotient is known to fit QW bits, so only the top QW bit positions run
  logic [NW-1:0] rem_r [1:QW];
  logic [DW-1:0] den_r [1:QW];
  logic [QW-1:0] q_r   [1:QW];
  logic          v_r   [1:QW];
  logic          tag_r [1:QW];

  for (genvar i = 0; i < QW; i++) begin : g_stage
    localparam int unsigned SH = QW - 1 - i;
    logic [NW-1:0]  rem_in;
    logic [DW-1:0]  den_in;
    logic [QW-1:0]  q_in;
    logic           v_in;
    logic           tag_in;
    logic [NW+QW:0] dsh;
    logic           take;

    // first stage takes the ports, later stages the previous registers
    if (i == 0) begin : g_first
      assign rem_in = num;
      assign den_in = den;
      assign q_in   = '0;
      assign v_in   = in_valid;
      assign tag_in = in_tag;
    end else begin : g_next
      assign rem_in = rem_r[i];
      assign den_in = den_r[i];
      assign q_in   = q_r[i];
      assign v_in   = v_r[i];
      assign tag_in = tag_r[i];
    end

    assign dsh  = (NW + QW + 1)'(den_in) << SH;
    assign take = (NW + QW + 1)'(rem_in) >= dsh;
    always_ff @(posedge clk) begin
      if (!rst_n) v_r[i+1] <= 1'b0;
      else v_r[i+1] <= v_in;
      rem_r[i+1] <= take ? NW'((NW + QW + 1)'(rem_in) - dsh) : rem_in;
      den_r[i+1] <= den_in;
      q_r[i+1]   <= {q_in[QW-2:0], take};
      tag_r[i+1] <= tag_in;
    end
  end

  assign out_valid = v_r[QW];
  assign quo       = q_r[QW];
  assign out_tag   = tag_r[QW];
endmodule

FILE: src/one_back.sv
// ----------------------------------------------------------------------------
// one_back: code scaling and the two dividers
// Forms S*t + m over 2m, divides both codes and packs the result word.
// ----------------------------------------------------------------------------
module one_back
  import one_pkg::*;
#(
  parameter int unsigned CB = 16,
  parameter int unsigned KB = 16
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   q_valid,
  input  logic [CB+1:0]          q_m,
  input  logic [CB+2:0]          q_tu,
  input  logic [CB+2:0]          q_tv,
  input  logic                   q_zero,
  output logic                   out_valid,
  output logic [PACKED_BITS-1:0] out_code,
  output logic                   out_zero
);
  localparam int unsigned NW = CB + 3 + KB + 1;
  localparam int unsigned DW = CB + 3;

  logic          v_r, zero_r;
  logic [NW-1:0] nu_r, nv_r;
  logic [DW-1:0] d_r;
  logic [KB-1:0] cu, cv;
  logic          vu, vv, zu, zv;

  // scale stage: S*t + m = (t << KB) - t + m
  always_ff @(posedge clk) begin
    if (!rst_n) v_r <= 1'b0;
    else v_r <= q_valid;
    nu_r   <= (NW'(q_tu) << KB) - NW'(q_tu) + NW'(q_m);
    nv_r   <= (NW'(q_tv) << KB) - NW'(q_tv) + NW'(q_m);
    d_r    <= {q_m, 1'b0};
    zero_r <= q_zero;
  end

  one_div #(.NW(NW), .DW(DW), .QW(KB)) u_div_u (
    .clk, .rst_n, .in_valid(v_r), .num(nu_r), .den(d_r), .in_tag(zero_r),
    .out_valid(vu), .quo(cu), .out_tag(zu));
  one_div #(.NW(NW), .DW(DW), .QW(KB)) u_div_v (
    .clk, .rst_n, .in_valid(v_r), .num(nv_r), .den(d_r), .in_tag(zero_r),
    .out_valid(vv), .quo(cv), .out_tag(zv));

  assign out_valid = vu & vv;
  assign out_zero  = zu | zv;
  assign out_code  = out_zero ? '0 :
      {CODE_SLOT'(cv), CODE_SLOT'(cu)};
endmodule

FILE: src/octahedral_normal_encoder.sv
// ----------------------------------------------------------------------------
// octahedral_normal_encoder: octahedral encoding of a direction vector
// Pipelined encoder, one vector per clock, fixed latency.
// ----------------------------------------------------------------------------
// Takes one vector per cycle (busy is always low) and gives its result on
// out_valid for one cycle; the receiver cannot stall. The latency is set by
// the front register, the scale register and the restoring dividers, one
// quotient bit per stage.
module octahedral_normal_encoder
  import one_pkg::*;
#(
  parameter int unsigned COMPONENT_BITS = 16,
  parameter int unsigned CODE_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          start,
  output logic                          busy,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_x,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_y,
  input  logic signed [COMPONENT_BITS-1:0] in_vec_z,
  output logic                          out_valid,
  output logic [PACKED_BITS-1:0]        out_packed_code,
  output logic                          out_zero_vector
);
  logic                      qv, qz;
  logic [COMPONENT_BITS+1:0] qm;
  logic [COMPONENT_BITS+2:0] qtu, qtv;

  assign busy = 1'b0;

  one_front #(.CB(COMPONENT_BITS)) u_front (
    .clk, .rst_n, .in_valid(start), .x(in_vec_x), .y(in_vec_y), .z(in_vec_z),
    .q_valid(qv), .q_m(qm), .q_tu(qtu), .q_tv(qtv), .q_zero(qz));

  one_back #(.CB(COMPONENT_BITS), .KB(CODE_BITS)) u_back (
    .clk, .rst_n, .q_valid(qv), .q_m(qm), .q_tu(qtu), .q_tv(qtv), .q_zero(qz),
    .out_valid, .out_code(out_packed_code), .out_zero(out_zero_vector));
endmodule

FILE: src/octahedral_normal_encoder_chk.sv
// ----------------------------------------------------------------------------
// octahedral_normal_encoder_chk: port-level checks
// Latency, busy, zero flag and u code range as seen at the top level.
// ----------------------------------------------------------------------------
`include "octahedral_normal_encoder_assert.svh"
module octahedral_normal_encoder_chk #(
  parameter int unsigned CODE_BITS = 16
) (
  input logic        clk,
  input logic        rst_n,
  input logic        start,
  input logic        busy,
  input logic        out_valid,
  input logic [31:0] out_packed_code,
  input logic        out_zero_vector
);
  `ONE_CHECK(a_zero_code, clk, rst_n, (out_valid && out_zero_vector) |-> (out_packed_code == '0), "zero vector with nonzero code")
  `ONE_CHECK(a_latency, clk, rst_n, (start && !busy) |-> ##(CODE_BITS + 2) out_valid, "result missing after fixed latency")
  `ONE_CHECK(a_no_busy, clk, rst_n, !busy, "busy raised")
  `ONE_CHECK(a_slot_u, clk, rst_n, out_valid |-> ((out_packed_code[15:0] >> CODE_BITS) == 0), "u code exceeds width")
endmodule

bind octahedral_normal_encoder octahedral_normal_encoder_chk #(.CODE_BITS(CODE_BITS)) u_chk (
  .clk, .rst_n, .start, .busy, .out_valid, .out_packed_code, .out_zero_vector);
